>>> design/i2cmls_pkg.sv
// ----------------------------------------------------------------------------
// I2C master line sequencer package
// Shared types, command and phase codes, and the phase sequence tables.
// ----------------------------------------------------------------------------
package i2cmls_pkg;

   localparam int PHASE_COUNT_WIDTH = 16;

   typedef logic [2:0]                   kind_type;
   typedef logic [7:0]                   byte_type;
   typedef logic [15:0]                  ticks_type;
   typedef logic [4:0]                   step_type;
   typedef logic [2:0]                   bit_index_type;
   typedef logic [2:0]                   op_type;
   typedef logic [PHASE_COUNT_WIDTH-1:0] count_type;

   localparam kind_type CMD_NONE      = 3'd0;
   localparam kind_type CMD_START     = 3'd1;
   localparam kind_type CMD_STOP      = 3'd2;
   localparam kind_type CMD_WRITE     = 3'd3;
   localparam kind_type CMD_READ      = 3'd4;
   localparam kind_type CMD_SEND_ACK  = 3'd5;
   localparam kind_type CMD_SEND_NACK = 3'd6;
   localparam kind_type CMD_READ_ACK  = 3'd7;

   localparam op_type OP_SCL0       = 3'd0;
   localparam op_type OP_SCL1       = 3'd1;
   localparam op_type OP_SDA0       = 3'd2;
   localparam op_type OP_SDA1       = 3'd3;
   localparam op_type OP_SDA_BIT    = 3'd4;
   localparam op_type OP_SAMPLE_BIT = 3'd5;
   localparam op_type OP_SAMPLE_ACK = 3'd6;

   localparam ticks_type PHASE_TICKS_RESET = 16'd1000;

   localparam logic [32:0] COUNT_MAX_WIDE = (33'd1 << PHASE_COUNT_WIDTH) - 33'd1;
   localparam count_type   COUNT_MAX      = PHASE_COUNT_WIDTH'(COUNT_MAX_WIDE);

   typedef struct packed {
      kind_type kind;
      byte_type write_byte;
      logic     sda_in;
   } req_item_type;

   typedef struct packed {
      logic     scl_out;
      logic     sda_out;
      logic     busy_res;
      logic     done_res;
      byte_type read_data;
      logic     nack_seen;
   } rsp_item_type;

   // Phase length actually used: zero counts as one, and values beyond the
   // counter range saturate.
   function automatic count_type phase_limit(input ticks_type ticks);
      logic [32:0] wide;
      wide = 33'(ticks);
      if (ticks == 16'd0) begin
         return PHASE_COUNT_WIDTH'(1);
      end else if (wide > COUNT_MAX_WIDE) begin
         return COUNT_MAX;
      end
      return PHASE_COUNT_WIDTH'(ticks);
   endfunction

   // Step divided by three for steps below 32, by reciprocal multiplication.
   function automatic logic [3:0] step_div3(input step_type st);
      logic [9:0] prod;
      prod = 10'(st) * 10'd11;
      return prod[8:5];
   endfunction

   function automatic logic [1:0] step_mod3(input step_type st);
      logic [5:0] rem;
      rem = 6'(st) - 6'(step_div3(st)) * 6'd3;
      return rem[1:0];
   endfunction

   function automatic step_type seq_len(input kind_type cmd);
      case (cmd)
         CMD_START:     return 5'd4;
         CMD_STOP:      return 5'd3;
         CMD_WRITE:     return 5'd24;
         CMD_READ:      return 5'd25;
         CMD_SEND_ACK:  return 5'd3;
         CMD_SEND_NACK: return 5'd3;
         CMD_READ_ACK:  return 5'd4;
         default:       return 5'd0;
      endcase
   endfunction

   function automatic op_type seq_op(input kind_type cmd, input step_type st);
      op_type op;
      op = OP_SCL0;
      case (cmd)
         CMD_START: begin
            case (st)
               5'd0:    op = OP_SDA1;
               5'd1:    op = OP_SCL1;
               5'd2:    op = OP_SDA0;
               default: op = OP_SCL0;
            endcase
         end
         CMD_STOP: begin
            case (st)
               5'd0:    op = OP_SDA0;
               5'd1:    op = OP_SCL1;
               default: op = OP_SDA1;
            endcase
         end
         CMD_WRITE: begin
            case (step_mod3(st))
               2'd0:    op = OP_SDA_BIT;
               2'd1:    op = OP_SCL1;
               default: op = OP_SCL0;
            endcase
         end
         CMD_READ: begin
            if (st == 5'd0) begin
               op = OP_SDA1;
            end else begin
               case (step_mod3(st - 5'd1))
                  2'd0:    op = OP_SCL1;
                  2'd1:    op = OP_SAMPLE_BIT;
                  default: op = OP_SCL0;
               endcase
            end
         end
         CMD_SEND_ACK, CMD_SEND_NACK: begin
            case (st)
               5'd0:    op = (cmd == CMD_SEND_ACK) ? OP_SDA0 : OP_SDA1;
               5'd1:    op = OP_SCL1;
               default: op = OP_SCL0;
            endcase
         end
         CMD_READ_ACK: begin
            case (st)
               5'd0:    op = OP_SDA1;
               5'd1:    op = OP_SCL1;
               5'd2:    op = OP_SAMPLE_ACK;
               default: op = OP_SCL0;
            endcase
         end
         default: op = OP_SCL0;
      endcase
      return op;
   endfunction

endpackage

>>> design/i2cmls_if.sv
// ----------------------------------------------------------------------------
// I2C master line sequencer channels
// Valid/ready channel interfaces for ticks, results and the phase register.
// ----------------------------------------------------------------------------
interface i2cmls_req_if
   import i2cmls_pkg::*;
();
   logic     valid;
   logic     ready;
   kind_type kind;
   byte_type write_byte;
   logic     sda_in;

   modport source (output valid, kind, write_byte, sda_in, input ready);
   modport sink   (input valid, kind, write_byte, sda_in, output ready);
endinterface

interface i2cmls_rsp_if
   import i2cmls_pkg::*;
();
   logic     valid;
   logic     ready;
   logic     scl_out;
   logic     sda_out;
   logic     busy_res;
   logic     done_res;
   byte_type read_data;
   logic     nack_seen;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data,
                   nack_seen, input ready);
   modport sink   (input valid, scl_out, sda_out, busy_res, done_res, read_data,
                   nack_seen, output ready);
endinterface

interface i2cmls_csr_if
   import i2cmls_pkg::*;
();
   logic      valid;
   logic      ready;
   ticks_type phase_ticks;

   modport source (output valid, phase_ticks, input ready);
   modport sink   (input valid, phase_ticks, output ready);
endinterface

>>> design/i2cmls_input_stage.sv
// ----------------------------------------------------------------------------
// I2C master line sequencer input stage
// Holds one accepted tick until the sequencer consumes it.
// ----------------------------------------------------------------------------
module i2cmls_input_stage
   import i2cmls_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   i2cmls_req_if.sink   req,
   input  logic         drain,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   // The register can load while its current item leaves in the same cycle.
   assign req.ready = !valid_ff || drain;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (drain) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{kind: req.kind, write_byte: req.write_byte, sda_in: req.sda_in};
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> design/i2cmls_sequencer.sv
// ----------------------------------------------------------------------------
// I2C master line sequencer core
// Command state, phase counter, line levels and the phase length register.
// ----------------------------------------------------------------------------
module i2cmls_sequencer
   import i2cmls_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   i2cmls_csr_if.sink   csr,
   input  logic         step_en,
   input  req_item_type item,
   output rsp_item_type result
);

   count_type limit_ff;
   kind_type  act_ff,   act_in;
   step_type  step_ff,  step_in;
   count_type cnt_ff,   cnt_in;
   byte_type  shift_ff, shift_in;
   logic      scl_ff,   scl_in;
   logic      sda_ff,   sda_in;
   logic      ack_ff,   ack_in;
   byte_type  rd_ff,    rd_in;
   logic      done;
   logic      run;
   count_type cnt_next;
   step_type  step_next;
   op_type    op;
   logic [3:0] quot;
   bit_index_type pos;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= phase_limit(PHASE_TICKS_RESET);
      end else if (csr.valid) begin
         limit_ff <= phase_limit(csr.phase_ticks);
      end
   end

   always_comb begin
      act_in    = act_ff;
      step_in   = step_ff;
      cnt_in    = cnt_ff;
      shift_in  = shift_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      ack_in    = ack_ff;
      rd_in     = rd_ff;
      done      = 1'b0;
      run       = 1'b0;
      cnt_next  = cnt_ff + PHASE_COUNT_WIDTH'(1);
      step_next = step_ff + 5'd1;
      op        = OP_SCL0;
      quot      = 4'd0;
      pos       = 3'd0;

      if (act_ff == CMD_NONE) begin
         if (item.kind != CMD_NONE) begin
            act_in   = item.kind;
            step_in  = 5'd0;
            cnt_in   = '0;
            shift_in = (item.kind == CMD_WRITE) ? item.write_byte : 8'd0;
            run      = 1'b1;
         end
      end else if (cnt_next >= limit_ff) begin
         cnt_in = '0;
         if (step_next >= seq_len(act_ff)) begin
            if (act_ff == CMD_READ) begin
               rd_in = shift_ff;
            end
            act_in  = CMD_NONE;
            step_in = 5'd0;
            done    = 1'b1;
         end else begin
            step_in = step_next;
            run     = 1'b1;
         end
      end else begin
         cnt_in = cnt_next;
      end

      if (run) begin
         op = seq_op(act_in, step_in);
         case (op)
            OP_SCL0: scl_in = 1'b0;
            OP_SCL1: scl_in = 1'b1;
            OP_SDA0: sda_in = 1'b0;
            OP_SDA1: sda_in = 1'b1;
            OP_SDA_BIT: begin
               // Bits go out most significant first.
               quot   = step_div3(step_in);
               pos    = ~quot[2:0];
               sda_in = shift_in[pos];
            end
            OP_SAMPLE_BIT: begin
               quot = step_div3(step_in - 5'd2);
               pos  = ~quot[2:0];
               if (item.sda_in) begin
                  shift_in[pos] = 1'b1;
               end
            end
            OP_SAMPLE_ACK: ack_in = item.sda_in;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff   <= CMD_NONE;
         step_ff  <= 5'd0;
         cnt_ff   <= '0;
         shift_ff <= 8'd0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ack_ff   <= 1'b0;
         rd_ff    <= 8'd0;
      end else if (step_en) begin
         act_ff   <= act_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
         shift_ff <= shift_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in;
         ack_ff   <= ack_in;
         rd_ff    <= rd_in;
      end
   end

   assign result = '{scl_out:   scl_in,
                     sda_out:   sda_in,
                     busy_res:  (act_in != CMD_NONE),
                     done_res:  done,
                     read_data: rd_in,
                     nack_seen: ack_in};

endmodule

>>> design/i2cmls_output_stage.sv
// ----------------------------------------------------------------------------
// I2C master line sequencer output stage
// Result register that holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module i2cmls_output_stage
   import i2cmls_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type result,
   output logic         stalled,
   i2cmls_rsp_if.source rsp
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type result_ff;

   assign stalled = valid_ff && !rsp.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.scl_out   = result_ff.scl_out;
   assign rsp.sda_out   = result_ff.sda_out;
   assign rsp.busy_res  = result_ff.busy_res;
   assign rsp.done_res  = result_ff.done_res;
   assign rsp.read_data = result_ff.read_data;
   assign rsp.nack_seen = result_ff.nack_seen;

endmodule

>>> design/i2c_master_line_sequencer_top.sv
// ----------------------------------------------------------------------------
// I2C master line sequencer, top level
// Bit-banged I2C master that steps SCL and SDA through command phases.
// ----------------------------------------------------------------------------
// Path: an accepted tick waits in the input register; when it advances, its
// result is loaded into the result register and offered to the sink.
// Throughput: one tick per cycle; the input register and the result register
// both load and unload in the same cycle, so stalls only pause the flow.
// Reset: synchronous, active high; the sequencer returns to idle with both
// lines released, the held read byte and ack bit cleared, phase length 1000.
// ----------------------------------------------------------------------------
module i2c_master_line_sequencer_top
   import i2cmls_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   i2cmls_req_if.sink   req,
   i2cmls_rsp_if.source rsp,
   i2cmls_csr_if.sink   csr
);

   // The input register captures each tick item. When the result register is
   // free, or is being emptied in this cycle, the held item advances: the
   // sequencer state updates and the result register loads in the same edge.
   logic         item_valid;
   req_item_type item;
   rsp_item_type result;
   logic         stalled;
   logic         advance;

   assign advance = item_valid && !stalled;

   i2cmls_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .drain      (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // The sequencer holds the command state, step index and phase counter.
   // A command only starts while idle; commands arriving while busy, the
   // finishing tick included, are dropped. Each phase's line action happens
   // on its first tick, and the done pulse comes on the tick after the last
   // phase expires.
   i2cmls_sequencer u_sequencer (
      .clock   (clock),
      .reset   (reset),
      .csr     (csr),
      .step_en (advance),
      .item    (item),
      .result  (result)
   );

   // The result register separates the two handshakes, so a new tick is
   // accepted while an earlier result waits for the sink.
   i2cmls_output_stage u_output (
      .clock   (clock),
      .reset   (reset),
      .load    (advance),
      .result  (result),
      .stalled (stalled),
      .rsp     (rsp)
   );

endmodule

>>> tb/sv/i2cmls_line_checker.sv
// ----------------------------------------------------------------------------
// I2C master line sequencer checker
// Watches the tick, result and phase register channels, keeps its own model
// of the line sequencer and compares every result with the predicted levels.
// ----------------------------------------------------------------------------
module i2cmls_line_checker
   import i2cmls_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   i2cmls_req_if req,
   i2cmls_rsp_if rsp,
   i2cmls_csr_if csr,
   output int    fail_count,
   output int    pending_count,
   output int    checked_count,
   output int    completed_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Model state of the sequencer.
   ticks_type line_ticks;
   kind_type  cur_cmd;
   step_type  cur_step;
   count_type phase_count;
   byte_type  shifter;
   logic      scl_level;
   logic      sda_level;
   logic      ack_level;
   byte_type  held_byte;

   rsp_item_type expected_levels[$];
   int mismatches = 0;
   int checked    = 0;
   int completed  = 0;

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] checker: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                   checked, name, got, want));
      end
   endtask

   function automatic void reset_line();
      line_ticks  = PHASE_TICKS_RESET;
      cur_cmd     = CMD_NONE;
      cur_step    = '0;
      phase_count = '0;
      shifter     = '0;
      scl_level   = 1'b1;
      sda_level   = 1'b1;
      ack_level   = 1'b0;
      held_byte   = '0;
   endfunction

   function automatic int phases_of(input kind_type cmd);
      case (cmd)
         CMD_START, CMD_READ_ACK:                return 4;
         CMD_STOP, CMD_SEND_ACK, CMD_SEND_NACK: return 3;
         CMD_WRITE:                              return 24;
         CMD_READ:                               return 25;
         default:                                return 0;
      endcase
   endfunction

   // Zero means one tick per phase; anything beyond the counter saturates.
   function automatic count_type ticks_to_limit(input ticks_type ticks);
      if (ticks == '0) begin
         return count_type'(1);
      end
      if (33'(ticks) > 33'(COUNT_MAX)) begin
         return COUNT_MAX;
      end
      return count_type'(ticks);
   endfunction

   // Line action on the first tick of the current phase.
   function automatic void apply_phase(input logic sda);
      int st;
      st = int'(cur_step);
      case (cur_cmd)
         CMD_START: begin
            case (st)
               0:       sda_level = 1'b1;
               1:       scl_level = 1'b1;
               2:       sda_level = 1'b0;
               default: scl_level = 1'b0;
            endcase
         end
         CMD_STOP: begin
            case (st)
               0:       sda_level = 1'b0;
               1:       scl_level = 1'b1;
               default: sda_level = 1'b1;
            endcase
         end
         CMD_WRITE: begin
            if (st % 3 == 0) begin
               sda_level = shifter[7 - st / 3];
            end else begin
               scl_level = (st % 3 == 1);
            end
         end
         CMD_READ: begin
            if (st == 0) begin
               sda_level = 1'b1;
            end else begin
               case ((st - 1) % 3)
                  0: scl_level = 1'b1;
                  1: begin
                     if (sda) begin
                        shifter[7 - (st - 2) / 3] = 1'b1;
                     end
                  end
                  default: scl_level = 1'b0;
               endcase
            end
         end
         CMD_SEND_ACK, CMD_SEND_NACK: begin
            case (st)
               0:       sda_level = (cur_cmd == CMD_SEND_NACK);
               1:       scl_level = 1'b1;
               default: scl_level = 1'b0;
            endcase
         end
         CMD_READ_ACK: begin
            case (st)
               0:       sda_level = 1'b1;
               1:       scl_level = 1'b1;
               2:       ack_level = sda;
               default: scl_level = 1'b0;
            endcase
         end
         default: ;
      endcase
   endfunction

   function automatic rsp_item_type predict_tick(input kind_type kind, input byte_type wbyte,
                                                 input logic sda);
      rsp_item_type r;
      count_type    limit;
      logic         finished;
      finished = 1'b0;
      limit    = ticks_to_limit(line_ticks);
      if (cur_cmd == CMD_NONE) begin
         if (kind != CMD_NONE) begin
            cur_cmd     = kind;
            cur_step    = '0;
            phase_count = '0;
            shifter     = (kind == CMD_WRITE) ? wbyte : '0;
            apply_phase(sda);
         end
      end else begin
         phase_count = phase_count + 1'b1;
         if (phase_count >= limit) begin
            phase_count = '0;
            cur_step    = cur_step + 1'b1;
            if (int'(cur_step) >= phases_of(cur_cmd)) begin
               if (cur_cmd == CMD_READ) begin
                  held_byte = shifter;
               end
               cur_cmd  = CMD_NONE;
               cur_step = '0;
               finished = 1'b1;
            end else begin
               apply_phase(sda);
            end
         end
      end
      r.scl_out   = scl_level;
      r.sda_out   = sda_level;
      r.busy_res  = (cur_cmd != CMD_NONE);
      r.done_res  = finished;
      r.read_data = held_byte;
      r.nack_seen = ack_level;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_item_type want;
      if (reset) begin
         reset_line();
         expected_levels.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            line_ticks = csr.phase_ticks;
         end
         // Results pass through the input and result registers after their tick, so a
         // result taken at this edge never belongs to a tick taken at the same edge.
         if (rsp.valid && rsp.ready) begin
            if (expected_levels.size() == 0) begin
               report_mismatch("result arrived with no tick waiting for it");
            end else begin
               want = expected_levels.pop_front();
               checked++;
               check_field("scl_out",   8'(rsp.scl_out),   8'(want.scl_out));
               check_field("sda_out",   8'(rsp.sda_out),   8'(want.sda_out));
               check_field("busy_res",  8'(rsp.busy_res),  8'(want.busy_res));
               check_field("done_res",  8'(rsp.done_res),  8'(want.done_res));
               check_field("read_data", rsp.read_data,     want.read_data);
               check_field("nack_seen", 8'(rsp.nack_seen), 8'(want.nack_seen));
            end
         end
         if (req.valid && req.ready) begin
            expected_levels.push_back(predict_tick(req.kind, req.write_byte, req.sda_in));
            if (expected_levels[$].done_res) begin
               completed++;
            end
         end
      end
      fail_count      <= mismatches;
      pending_count   <= expected_levels.size();
      checked_count   <= checked;
      completed_count <= completed;
   end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// I2C master line sequencer testbench
// Drives clock ticks with commands and sampled SDA levels into the sequencer,
// steps the phase length through several settings, and lets the checker
// compare every per-tick result with its predicted line levels.
// ----------------------------------------------------------------------------
module tb_top
   import i2cmls_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // The run is ended by the watchdog when this many cycles pass in which no
   // channel moves an item. A correct block never comes close to it: the
   // longest quiet stretch is a sender gap plus a receiver stall plus the
   // passage through the input and result registers.
   localparam int WATCHDOG_LIMIT = 1000;

   // How the SDA level that comes with each tick is chosen.
   localparam int SDA_RANDOM = 0;
   localparam int SDA_HIGH   = 1;
   localparam int SDA_LOW    = 2;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   i2cmls_req_if req_ch ();
   i2cmls_rsp_if rsp_ch ();
   i2cmls_csr_if csr_ch ();

   i2c_master_line_sequencer_top dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   int fail_count;
   int pending_count;
   int checked_count;
   int completed_count;

   i2cmls_line_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req             (req_ch),
      .rsp             (rsp_ch),
      .csr             (csr_ch),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count),
      .completed_count (completed_count)
   );

   // Stimulus bookkeeping. ticks_now mirrors the phase register so that the
   // command pacing below knows how long each command keeps the block busy.
   ticks_type ticks_now;
   int        ticks_sent       = 0;
   int        settings_written = 0;
   bit        gaps_on          = 1'b1;
   bit        stalls_on        = 1'b1;
   int        quiet_cycles     = 0;

   // Watchdog: counts cycles in which no item moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d quiet cycles with %0d results outstanding.",
                  quiet_cycles, pending_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Result side: for every item the receiver may first hold ready low while
   // stalls are enabled, and then waits with ready high until the block hands
   // over a result.
   initial begin : result_sink
      int stall;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         stall = stalls_on ? $urandom_range(0, 3) : 0;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) begin
            @(posedge clock);
         end
      end
   end

   function automatic logic sda_for(input int mode);
      case (mode)
         SDA_HIGH: return 1'b1;
         SDA_LOW:  return 1'b0;
         default:  return 1'($urandom);
      endcase
   endfunction

   // Data bytes lean toward the all-zero and all-one patterns now and then.
   function automatic byte_type data_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Where the next command lands relative to the done tick of the current
   // one. Mostly just after it, so the sequence is well formed; sometimes on
   // the done tick itself or while the block is still busy, where the
   // command must be ignored.
   function automatic int next_command_offset();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return -int'($urandom_range(1, 2));
      end else if (r == 1) begin
         return 0;
      end
      return $urandom_range(1, 3);
   endfunction

   // Moves one item into the block. The sender may idle first if gaps are on.
   // Called right after a rising edge; returns right after the accepting one.
   task automatic send_tick(input kind_type kind, input byte_type wbyte, input logic sda);
      int gap;
      gap = gaps_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.write_byte <= wbyte;
      req_ch.sda_in     <= sda;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      ticks_sent++;
   endtask

   // Stops sending and waits until every expected result has been taken.
   // The first edge lets the checker count an item accepted at the last edge.
   task automatic pause_until_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) begin
         @(posedge clock);
      end
   endtask

   // The phase register is only written with the block drained. Every item
   // produces a result, so once nothing is outstanding nothing is in flight.
   task automatic write_phase_ticks(input ticks_type ticks);
      pause_until_drained();
      csr_ch.valid       <= 1'b1;
      csr_ch.phase_ticks <= ticks;
      @(posedge clock);
      while (!csr_ch.ready) begin
         @(posedge clock);
      end
      csr_ch.valid <= 1'b0;
      ticks_now = ticks;
      settings_written++;
   endtask

   // Sends a command tick, then enough idle ticks to carry the command to its
   // done tick, shifted by offset. While the block is busy a few of those
   // ticks carry a stray command, which must be ignored.
   task automatic run_command(input kind_type kind, input byte_type wbyte, input int offset,
                              input int sda_mode);
      int       busy_ticks;
      kind_type filler;
      busy_ticks = int'(seq_len(kind)) * ((ticks_now == '0) ? 1 : int'(ticks_now));
      send_tick(kind, wbyte, sda_for(sda_mode));
      for (int i = 0; i < busy_ticks + offset; i++) begin
         filler = CMD_NONE;
         if (i < busy_ticks && $urandom_range(0, 19) == 0) begin
            filler = kind_type'($urandom_range(1, 7));
         end
         send_tick(filler, 8'($urandom), sda_for(sda_mode));
      end
   endtask

   // One bus transaction: start, address byte, ack check, up to two data bytes
   // in either direction, stop.
   task automatic run_transaction();
      int data_bytes;
      data_bytes = $urandom_range(0, 2);
      run_command(CMD_START, 8'($urandom), next_command_offset(), SDA_RANDOM);
      run_command(CMD_WRITE, data_byte(), next_command_offset(), SDA_RANDOM);
      run_command(CMD_READ_ACK, 8'($urandom), next_command_offset(), SDA_RANDOM);
      for (int n = 0; n < data_bytes; n++) begin
         if ($urandom_range(0, 1) == 1) begin
            run_command(CMD_WRITE, data_byte(), next_command_offset(), SDA_RANDOM);
            run_command(CMD_READ_ACK, 8'($urandom), next_command_offset(), SDA_RANDOM);
         end else begin
            run_command(CMD_READ, 8'($urandom), next_command_offset(), SDA_RANDOM);
            run_command((n == data_bytes - 1) ? CMD_SEND_NACK : CMD_SEND_ACK, 8'($urandom),
                        next_command_offset(), SDA_RANDOM);
         end
      end
      run_command(CMD_STOP, 8'($urandom), next_command_offset(), SDA_RANDOM);
   endtask

   // Unpaced ticks with any command at all.
   task automatic run_noise_burst();
      repeat ($urandom_range(4, 24)) begin
         send_tick(kind_type'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
      end
   endtask

   // One phase length setting with randomized transactions and noise. The
   // idling of both sides is redrawn before each transaction, so some
   // stretches run with no gaps or stalls at all.
   task automatic run_random_phase(input ticks_type ticks, input int budget);
      int first;
      write_phase_ticks(ticks);
      first = ticks_sent;
      while (ticks_sent - first < budget) begin
         gaps_on   = ($urandom_range(0, 3) != 0);
         stalls_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 5) == 0) begin
            run_noise_burst();
         end else begin
            run_transaction();
         end
      end
   endtask

   initial begin : stimulus
      req_ch.valid       <= 1'b0;
      req_ch.kind        <= CMD_NONE;
      req_ch.write_byte  <= 8'h00;
      req_ch.sda_in      <= 1'b1;
      csr_ch.valid       <= 1'b0;
      csr_ch.phase_ticks <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset state and the default phase length: a start command holds its
      // first phase for the whole stretch.
      ticks_now = PHASE_TICKS_RESET;
      send_tick(CMD_START, 8'h00, 1'b1);
      repeat (20) send_tick(CMD_NONE, 8'($urandom), 1'($urandom));

      // Directed part at one tick per phase: every command, both extreme
      // write bytes, read bytes and ack samples with SDA held high and low,
      // a command issued while busy and one issued on the done tick.
      write_phase_ticks(16'd1);
      run_command(CMD_START, 8'h00, 1, SDA_RANDOM);
      run_command(CMD_WRITE, 8'hFF, 1, SDA_RANDOM);
      run_command(CMD_READ_ACK, 8'h00, 1, SDA_LOW);
      run_command(CMD_WRITE, 8'h00, -2, SDA_RANDOM);
      run_command(CMD_STOP, 8'h00, 1, SDA_RANDOM);
      run_command(CMD_READ_ACK, 8'h00, -1, SDA_HIGH);
      run_command(CMD_SEND_ACK, 8'h00, 1, SDA_RANDOM);
      run_command(CMD_READ, 8'h00, 1, SDA_HIGH);
      run_command(CMD_SEND_ACK, 8'h00, 1, SDA_RANDOM);
      run_command(CMD_READ, 8'hFF, 1, SDA_LOW);
      run_command(CMD_SEND_NACK, 8'h00, 1, SDA_RANDOM);
      run_command(CMD_READ, 8'h00, 1, SDA_RANDOM);
      run_command(CMD_STOP, 8'h00, 2, SDA_RANDOM);

      // Random part across several phase lengths, zero (treated as one)
      // among them.
      run_random_phase(16'd1, 220);
      run_random_phase(16'd2, 220);
      run_random_phase(16'd0, 180);

      // The longest phase length: a write starts and the register is then
      // changed in the middle of its first phase.
      write_phase_ticks(16'hFFFF);
      send_tick(CMD_WRITE, 8'hA5, 1'b0);
      repeat (40) send_tick(kind_type'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));

      run_random_phase(16'd3, 200);
      run_random_phase(16'd4, 150);
      run_random_phase(16'd1, 180);

      // Drain, then give the block a few more cycles in which any stray
      // result would be caught by the checker.
      pause_until_drained();
      repeat (8) @(posedge clock);

      $display("Run covered %0d ticks over %0d phase length settings, all seven commands,",
               ticks_sent, settings_written);
      $display("commands on busy and done ticks; %0d results compared, %0d sequences done.",
               checked_count, completed_count);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> sim.f
design/i2cmls_pkg.sv
design/i2cmls_if.sv
design/i2cmls_input_stage.sv
design/i2cmls_sequencer.sv
design/i2cmls_output_stage.sv
design/i2c_master_line_sequencer_top.sv
tb/sv/i2cmls_line_checker.sv
tb/sv/tb_top.sv
